// ----- rtl/core/npc_pkg.sv -----
// Shared types and constants for the nearest palette color unit.
// Used by npc_front, npc_back, nearest_palette_color_unit and the testbench; no dependencies.
package npc_pkg;

  localparam int CFG_W        = 9;
  localparam int FIELD_W      = 8;
  localparam int DIST_W       = 31;
  localparam logic [DIST_W-1:0] START_DISTANCE = 31'h7fffffff;

  localparam int QUEUE_DEPTH  = 2;
  localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_QUERY,
    KIND_SKIP
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [FIELD_W-1:0] slot;
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_DONE
  } back_state_t;

endpackage

// ----- rtl/core/npc_front.sv -----
// Front end: accepts requests, tags them as palette write, query or dropped write,
// and holds them in a short queue for the back end. Depends on npc_pkg.
module npc_front import npc_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [FIELD_W-1:0] in_entry_index,
  input  logic [FIELD_W-1:0] in_red,
  input  logic [FIELD_W-1:0] in_green,
  input  logic [FIELD_W-1:0] in_blue,
  output q_head_t            head,
  input  logic               pop
);

  item_t              q_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  item_t              new_item;
  logic               push;

  always_comb begin
    new_item.slot  = in_entry_index;
    new_item.red   = in_red;
    new_item.green = in_green;
    new_item.blue  = in_blue;
    if (in_mode) begin
      new_item.kind = KIND_QUERY;
    end else if (32'(in_entry_index) < PALETTE_DEPTH) begin
      new_item.kind = KIND_WRITE;
    end else begin
      new_item.kind = KIND_SKIP;
    end
  end

  assign in_ready   = (cnt_r != Q_CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop && head.valid) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop && head.valid})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ----- rtl/core/npc_back.sv -----
// Back end: palette memory, write execution and the pipelined nearest-entry scan,
// plus the result register. Depends on npc_pkg.
module npc_back import npc_pkg::*; #(
  parameter int PALETTE_DEPTH = 256,
  parameter int CHANNEL_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   entries_in_use,
  input  q_head_t            head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_nearest_index
);

  localparam int CB    = CHANNEL_BITS;
  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int SQ_W  = 2 * CB;
  localparam int SUM_W = SQ_W + 2;

  back_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_sat;
  logic [CB-1:0]      pix_r [3];
  logic [3*CB-1:0]    mem [PALETTE_DEPTH];
  logic [3*CB-1:0]    rd_data_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_v_r;
  logic [SQ_W-1:0]    sq_r [3];
  logic [IDX_W-1:0]   sq_idx_r;
  logic               sq_v_r;
  logic [DIST_W-1:0]  best_r;
  logic [IDX_W-1:0]   best_i_r;
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_index_r;

  logic               start_q;
  logic               mem_we;
  logic               rd_en;
  logic               load_out;
  logic [CB-1:0]      diff [3];
  logic [CB-1:0]      ent [3];
  logic [SUM_W-1:0]   dist_sum;

  assign count_sat = (32'(entries_in_use) > PALETTE_DEPTH) ?
                     CNT_W'(PALETTE_DEPTH) : CNT_W'(entries_in_use);

  always_comb begin
    state_nxt   = state_r;
    rd_addr_nxt = rd_addr_r;
    pop         = 1'b0;
    mem_we      = 1'b0;
    start_q     = 1'b0;
    rd_en       = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.item.kind)
            KIND_WRITE: mem_we = 1'b1;
            KIND_QUERY: begin
              start_q     = 1'b1;
              rd_addr_nxt = '0;
              state_nxt   = (count_sat == '0) ? B_DONE : B_SCAN;
            end
            default: ;
          endcase
        end
      end
      B_SCAN: begin
        rd_en = 1'b1;
        if (CNT_W'(rd_addr_r) == count_r - 1'b1) begin
          state_nxt = B_DRAIN;
        end else begin
          rd_addr_nxt = rd_addr_r + 1'b1;
        end
      end
      B_DRAIN: begin
        if (!rd_v_r && !sq_v_r) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    if (start_q) begin
      count_r  <= count_sat;
      pix_r[0] <= CB'(head.item.red);
      pix_r[1] <= CB'(head.item.green);
      pix_r[2] <= CB'(head.item.blue);
    end
  end

  // palette memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IDX_W'(32'(head.item.slot))] <= {CB'(head.item.red), CB'(head.item.green),
                                          CB'(head.item.blue)};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr_r];
      rd_idx_r  <= rd_addr_r;
    end
  end

  always_comb begin
    ent[0] = rd_data_r[3*CB-1:2*CB];
    ent[1] = rd_data_r[2*CB-1:CB];
    ent[2] = rd_data_r[CB-1:0];
    for (int k = 0; k < 3; k++) begin
      diff[k] = (pix_r[k] >= ent[k]) ? pix_r[k] - ent[k] : ent[k] - pix_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= SQ_W'(diff[k]) * SQ_W'(diff[k]);
    end
    sq_idx_r <= rd_idx_r;
  end

  assign dist_sum = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (start_q) begin
      best_r   <= START_DISTANCE;
      best_i_r <= '0;
    end else if (sq_v_r && (DIST_W'(dist_sum) < best_r)) begin
      best_r   <= DIST_W'(dist_sum);
      best_i_r <= sq_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      sq_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
      sq_v_r <= rd_v_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index_r <= FIELD_W'(best_i_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_index_r;

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DONE) |-> (!rd_v_r && !sq_v_r))
    else $error("result taken before scan pipeline drained");

  a_read_feeds_square: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |=> sq_v_r)
    else $error("read data lost in scan pipeline");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCAN) |-> (CNT_W'(rd_addr_r) < count_r))
    else $error("scan address beyond entries in use");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == B_IDLE && head.valid))
    else $error("queue popped while busy");

endmodule

// ----- rtl/core/nearest_palette_color_unit.sv -----
// Nearest palette color unit: top level with the entries-in-use register.
// Instantiates npc_front and npc_back; depends on npc_pkg.
//
// Input channel (in_valid/in_ready): in_mode 0 writes in_red/green/blue into
// palette slot in_entry_index (slots at or above PALETTE_DEPTH are dropped);
// in_mode 1 queries the pixel and yields one result on out_nearest_index,
// the lowest index of minimal squared RGB distance over entries
// 0..entries_in_use-1, or 0 when no entry is searched.
// cfg_we/cfg_wdata set entries_in_use (saturated to PALETTE_DEPTH); write it
// only while the block is idle. Queried entries must have been written.
// A two-entry queue separates request intake from execution, so requests keep
// being taken while a query runs, until the queue fills.
// A write executes while the back end is idle; a query scans the saturated
// entries_in_use entries (with none it goes straight to the result), the single
// palette read port reading one entry per cycle through a three-stage
// read/square/compare pipeline.
// Reset clears the queue, state and result valid and sets entries_in_use to 0;
// palette contents are undefined until written.
// If out_ready stays low the result is held and the back end waits with the
// next query's result; writes queued ahead of that query still execute.
module nearest_palette_color_unit import npc_pkg::*; #(
  parameter int PALETTE_DEPTH = 256,
  parameter int CHANNEL_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [FIELD_W-1:0] in_entry_index,
  input  logic [FIELD_W-1:0] in_red,
  input  logic [FIELD_W-1:0] in_green,
  input  logic [FIELD_W-1:0] in_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_nearest_index
);

  logic [CFG_W-1:0] entries_r;
  q_head_t          head;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_we) begin
      entries_r <= cfg_wdata;
    end
  end

  npc_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .head           (head),
    .pop            (pop)
  );

  npc_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .CHANNEL_BITS  (CHANNEL_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .entries_in_use    (entries_r),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_nearest_index (out_nearest_index)
  );

endmodule

// ----- tb/sv/nearest_palette_color_unit_test.sv -----
// Self-checking testbench for nearest_palette_color_unit: directed table, then random phases.
// Predicts each query's nearest palette index and checks it; depends on npc_pkg and the RTL.
module nearest_palette_color_unit_test import npc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int   DEPTH = 256;
  localparam int   FAR_DISTANCE = 32'h7fffffff;
  localparam int   SETTLE_CYCLES = 20;
  localparam int   STALL_LIMIT = 2000;
  localparam int   TOTAL_REQUESTS = 450;
  localparam int   PLAN_LEN = 27;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_QUERY,
    ROW_COUNT,
    ROW_FILL
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CFG_W-1:0]   count;
    logic [FIELD_W-1:0] slot;
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
    logic               pinned;
    logic [FIELD_W-1:0] pinned_index;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_mode = MODE_WRITE;
  logic [FIELD_W-1:0] in_entry_index = '0;
  logic [FIELD_W-1:0] in_red = '0;
  logic [FIELD_W-1:0] in_green = '0;
  logic [FIELD_W-1:0] in_blue = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] out_nearest_index;

  logic               pin_en = 1'b0;
  logic [FIELD_W-1:0] pin_val = '0;

  logic [23:0]        palette [DEPTH];
  bit                 filled [DEPTH];
  int                 span = 0;
  logic [FIELD_W-1:0] nearest_q [$];
  int                 errors = 0;
  int                 requests_sent = 0;
  bit                 steady = 1'b0;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_QUERY, 9'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{ROW_COUNT, 9'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
    '{ROW_WRITE, 9'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_WRITE, 9'd0,   8'd1,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
    '{ROW_WRITE, 9'd0,   8'd2,   8'd255, 8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_WRITE, 9'd0,   8'd3,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_WRITE, 9'd0,   8'd4,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
    '{ROW_WRITE, 9'd0,   8'd5,   8'd0,   8'd0,   8'd255, 1'b0, 8'd0},
    '{ROW_COUNT, 9'd6,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd1},
    '{ROW_QUERY, 9'd0,   8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 8'd2},
    '{ROW_QUERY, 9'd0,   8'd0,   8'd0,   8'd255, 8'd0,   1'b1, 8'd4},
    '{ROW_QUERY, 9'd0,   8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 8'd5},
    '{ROW_QUERY, 9'd0,   8'd0,   8'd128, 8'd128, 8'd128, 1'b0, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd170, 8'd200, 8'd40,  8'd90,  1'b0, 8'd0},
    '{ROW_COUNT, 9'd1,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
    '{ROW_WRITE, 9'd0,   8'd255, 8'd170, 8'd85,  8'd170, 1'b0, 8'd0},
    '{ROW_WRITE, 9'd0,   8'd0,   8'd85,  8'd170, 8'd85,  1'b0, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{ROW_FILL,  9'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_COUNT, 9'd511, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd0,   8'd170, 8'd85,  8'd170, 1'b0, 8'd0},
    '{ROW_COUNT, 9'd256, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_QUERY, 9'd0,   8'd85,  8'd85,  8'd170, 8'd85,  1'b1, 8'd0}
  };

  nearest_palette_color_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_nearest_index (out_nearest_index)
  );

  always #4 clk = ~clk;

  function automatic logic [FIELD_W-1:0] closest_entry(input logic [7:0] r, input logic [7:0] g,
                                                      input logic [7:0] b);
    int best;
    int sq_sum;
    int dr;
    int dg;
    int db;
    logic [FIELD_W-1:0] winner;
    best = FAR_DISTANCE;
    winner = '0;
    for (int i = 0; i < span; i++) begin
      dr = int'(r) - int'(palette[i][23:16]);
      dg = int'(g) - int'(palette[i][15:8]);
      db = int'(b) - int'(palette[i][7:0]);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum < best) begin
        best = sq_sum;
        winner = i[FIELD_W-1:0];
      end
    end
    return winner;
  endfunction

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic logic [7:0] jitter(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic int idle_gap();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // palette model, count register and expected index queue, all updated at the clock edge
  always @(posedge clk) begin
    logic [FIELD_W-1:0] want;
    if (rst_n) begin
      if (cfg_we) span = (cfg_wdata > DEPTH) ? DEPTH : int'(cfg_wdata);
      if (in_valid && in_ready) begin
        if (in_mode == MODE_QUERY) begin
          want = pin_en ? pin_val : closest_entry(in_red, in_green, in_blue);
          nearest_q.push_back(want);
        end else begin
          palette[in_entry_index] = {in_red, in_green, in_blue};
        end
      end
      if (out_valid && out_ready) begin
        if (nearest_q.size() == 0) begin
          note_failure($sformatf("unexpected result: nearest_index %0d", out_nearest_index));
        end else begin
          want = nearest_q.pop_front();
          if (want !== out_nearest_index)
            note_failure($sformatf("nearest_index mismatch: expected %0d, got %0d",
                                   want, out_nearest_index));
        end
      end
    end
  end

  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            out_ready <= 1'b1;
            hold = $urandom_range(0, 7);
          end
          6, 7: begin
            out_ready <= 1'b0;
            hold = $urandom_range(0, 2);
          end
          8: begin
            out_ready <= 1'b0;
            hold = $urandom_range(10, 40);
          end
          default: begin
            out_ready <= 1'b1;
            hold = $urandom_range(50, 150);
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
    $display("** nearest_palette_color_unit: FAILED **");
    $finish;
  end

  task automatic send_request(input logic mode, input logic [7:0] slot, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b, input logic pin,
                              input logic [7:0] pinned_index);
    int gap;
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_entry_index <= slot;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    pin_en         <= pin;
    pin_val        <= pinned_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (mode == MODE_WRITE) filled[slot] = 1'b1;
    requests_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (nearest_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_count(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_upto(input int limit);
    logic [23:0] color;
    for (int i = 0; i < limit; i++) begin
      if (!filled[i]) begin
        color = 24'($urandom);
        send_request(MODE_WRITE, i[7:0], color[23:16], color[15:8], color[7:0], 1'b0, 8'd0);
      end
    end
  endtask

  task automatic random_write(input int limit);
    logic [7:0]  slot;
    logic [23:0] color;
    int          src;
    if (limit > 0 && $urandom_range(0, 1) == 1) slot = 8'($urandom_range(0, limit - 1));
    else slot = 8'($urandom_range(0, DEPTH - 1));
    src = $urandom_range(0, DEPTH - 1);
    case ($urandom_range(0, 3))
      0: color = filled[src] ? palette[src] : 24'($urandom);
      1: color = {($urandom_range(0, 1) == 1) ? 8'hff : 8'h00,
                  ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00,
                  ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00};
      default: color = 24'($urandom);
    endcase
    send_request(MODE_WRITE, slot, color[23:16], color[15:8], color[7:0], 1'b0, 8'd0);
  endtask

  task automatic random_query(input int limit);
    logic [23:0] base;
    logic [23:0] pixel;
    base = (limit > 0) ? palette[$urandom_range(0, limit - 1)] : 24'($urandom);
    case ($urandom_range(0, 2))
      0: pixel = 24'($urandom);
      1: pixel = base;
      default: pixel = {jitter(base[23:16]), jitter(base[15:8]), jitter(base[7:0])};
    endcase
    send_request(MODE_QUERY, 8'($urandom), pixel[23:16], pixel[15:8], pixel[7:0], 1'b0, 8'd0);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] count;
    int               limit;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      case (plan[i].kind)
        ROW_WRITE, ROW_QUERY: begin
          send_request((plan[i].kind == ROW_QUERY) ? MODE_QUERY : MODE_WRITE, plan[i].slot,
                       plan[i].red, plan[i].green, plan[i].blue, plan[i].pinned,
                       plan[i].pinned_index);
        end
        ROW_COUNT: set_count(plan[i].count);
        default: fill_upto(DEPTH);
      endcase
    end

    while (requests_sent < TOTAL_REQUESTS) begin
      case ($urandom_range(0, 9))
        0: count = '0;
        1: count = 9'd1;
        2: count = 9'd2;
        3, 4, 5: count = 9'($urandom_range(3, 16));
        6: count = 9'($urandom_range(17, 64));
        7: count = 9'($urandom_range(65, 255));
        8: count = 9'(DEPTH);
        default: count = 9'($urandom_range(DEPTH + 1, 511));
      endcase
      limit = (count > DEPTH) ? DEPTH : int'(count);
      fill_upto(limit);
      set_count(count);
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 29) == 0) drain_results();
        if ($urandom_range(0, 99) < 45) random_write(limit);
        else random_query(limit);
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (nearest_q.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", nearest_q.size()));
    if (errors == 0) begin
      $display("** nearest_palette_color_unit: PASSED **");
    end else begin
      $display("** nearest_palette_color_unit: FAILED **");
    end
    $finish;
  end

endmodule
